/* rtl/pps_pkg.sv */
// ============================================================================
// pps_pkg: pin pattern sequencer shared definitions
// Types, constants and helper functions used by the sequencer modules.
// ============================================================================
`default_nettype none

package pps_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int STEP_W      = 10;

    // repeat limit value that plays without end
    localparam logic [7:0] FOREVER = 8'd255;

    // pin counts for the two modes
    localparam logic [5:0] LOW_PINS = 6'd16;
    localparam logic [5:0] ALL_PINS = 6'd32;

    // input commands carried in tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    // configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_REPEAT_LIMIT   = 3'd1,
        REG_REVERSE_ORDER  = 3'd2,
        REG_SHARED_DELAY   = 3'd3,
        REG_PIN_COUNT      = 3'd4
    } reg_idx_t;

    // configuration values seen by the sequencer core
    typedef struct packed {
        logic [8:0]  pattern_length;
        logic [7:0]  repeat_limit;
        logic        reverse_order;
        logic [15:0] shared_delay;
        logic [5:0]  pin_count;
    } pps_cfg_t;

    // mask of the n lowest pins
    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [31:0] m;
        if (n >= ALL_PINS) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = (32'd1 << n[4:0]) - 32'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/pps_apb_regs.sv */
// ============================================================================
// pps_apb_regs: configuration register file
// APB-style write and read access to the five sequencer settings.
// ============================================================================
`default_nettype none

module pps_apb_regs (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [4:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    output pps_pkg::pps_cfg_t    cfg
);
    import pps_pkg::*;

    pps_cfg_t cfg_reg;
    pps_cfg_t cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_PATTERN_LENGTH: cfg_next.pattern_length = pwdata[8:0];
                REG_REPEAT_LIMIT:   cfg_next.repeat_limit   = pwdata[7:0];
                REG_REVERSE_ORDER:  cfg_next.reverse_order  = pwdata[0];
                REG_SHARED_DELAY:   cfg_next.shared_delay   = pwdata[15:0];
                REG_PIN_COUNT:      cfg_next.pin_count      = pwdata[5:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_PATTERN_LENGTH: prdata = {23'd0, cfg_reg.pattern_length};
            REG_REPEAT_LIMIT:   prdata = {24'd0, cfg_reg.repeat_limit};
            REG_REVERSE_ORDER:  prdata = {31'd0, cfg_reg.reverse_order};
            REG_SHARED_DELAY:   prdata = {16'd0, cfg_reg.shared_delay};
            REG_PIN_COUNT:      prdata = {26'd0, cfg_reg.pin_count};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/pin_pattern_sequencer_top.sv */
// ============================================================================
// pin_pattern_sequencer_top: pin pattern sequencer
// Plays a loaded table of pin patterns on tick requests, with load, start
// and stop requests, one result per request.
// ============================================================================
// result: an accepted request's result is in the output register in the next cycle
// throughput: one request per cycle while the result stream is not stalled; the table
//   read for the next tick is registered from the next step index, with write bypass
// reset: rst_n clears step index, repeat count, due time, settings and the
//   output valid; the pattern table holds no reset and needs no clearing pass
`default_nettype none

module pin_pattern_sequencer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] now_ms, [39:32] entry_index, [71:40] entry_bits, [87:72] entry_delay
    input  wire logic [87:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] pins_written, [63:32] pin_levels, [64] playing, [71:65] zero
    output logic [71:0]      m_tdata,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pps_pkg::*;

    pps_cfg_t cfg;

    pps_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // request fields
    cmd_t        cmd;
    logic [31:0] now_ms;
    logic [7:0]  entry_index;
    logic [31:0] entry_bits;
    logic [15:0] entry_delay;

    assign cmd         = cmd_t'(s_tuser);
    assign now_ms      = s_tdata[31:0];
    assign entry_index = s_tdata[39:32];
    assign entry_bits  = s_tdata[71:40];
    assign entry_delay = s_tdata[87:72];

    // sequencer state
    logic [STEP_W-1:0] step_index_reg, step_index_next;
    logic [7:0]        repeat_count_reg, repeat_count_next;
    logic [31:0]       due_time_reg, due_time_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] pins_written_reg, pins_written_next;
    logic [31:0] pin_levels_reg, pin_levels_next;
    logic        playing_reg, playing_next;

    // table memory and its registered read
    logic [31:0]       bits_mem  [TABLE_DEPTH];
    logic [15:0]       delay_mem [TABLE_DEPTH];
    logic [31:0]       rd_bits_reg;
    logic [15:0]       rd_delay_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    logic accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // tick and command handling
    logic              still_playing;
    logic [8:0]        len;
    logic [5:0]        pins;
    logic [31:0]       mask;
    logic [15:0]       wait_ms;

    always_comb
    begin
        step_index_next   = step_index_reg;
        repeat_count_next = repeat_count_reg;
        due_time_next     = due_time_reg;
        pins_written_next = 32'd0;
        pin_levels_next   = 32'd0;
        mem_we            = 1'b0;

        still_playing = (repeat_count_reg < cfg.repeat_limit) ||
                        (cfg.repeat_limit == FOREVER && repeat_count_reg != FOREVER);
        len  = (cfg.pattern_length > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH)
                                                      : cfg.pattern_length;
        pins = (cfg.pin_count > ALL_PINS) ? ALL_PINS : cfg.pin_count;
        if (cfg.shared_delay != 16'd0)
        begin
            wait_ms = cfg.shared_delay;
        end
        else
        begin
            wait_ms = rd_delay_reg;
            if (pins > LOW_PINS)
            begin
                pins = LOW_PINS;
            end
        end
        mask = low_mask(pins);

        if (accept)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    if (still_playing && now_ms >= due_time_reg)
                    begin
                        if (step_index_reg < {1'b0, len})
                        begin
                            pins_written_next = mask;
                            pin_levels_next   = rd_bits_reg & mask;
                            due_time_next     = now_ms + {16'd0, wait_ms};
                            if (cfg.reverse_order)
                            begin
                                step_index_next = step_index_reg - STEP_W'(1);
                            end
                            else
                            begin
                                step_index_next = step_index_reg + STEP_W'(1);
                            end
                        end
                        else
                        begin
                            // end of a pass: wrap and, unless the limit is FOREVER, count a repeat
                            if (cfg.repeat_limit != FOREVER)
                            begin
                                repeat_count_next = repeat_count_reg + 8'd1;
                            end
                            if (cfg.reverse_order)
                            begin
                                step_index_next = {1'b0, len} - STEP_W'(1);
                            end
                            else
                            begin
                                step_index_next = '0;
                            end
                        end
                    end
                end
                CMD_LOAD:
                begin
                    mem_we = 32'(entry_index) < 32'(TABLE_DEPTH);
                end
                CMD_START:
                begin
                    repeat_count_next = 8'd0;
                    step_index_next   = '0;
                end
                default:
                begin
                    repeat_count_next = cfg.repeat_limit;
                end
            endcase
        end

        playing_next   = repeat_count_next != cfg.repeat_limit;
        out_valid_next = accept ? 1'b1 : (out_valid_reg && !m_tready);
    end

    assign mem_waddr = ADDR_W'(entry_index);
    assign mem_raddr = step_index_next[ADDR_W-1:0];

    // table write and read-ahead of the next step, write data bypassed
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bits_mem[mem_waddr]  <= entry_bits;
            delay_mem[mem_waddr] <= entry_delay;
        end
        if (mem_we && mem_waddr == mem_raddr)
        begin
            rd_bits_reg  <= entry_bits;
            rd_delay_reg <= entry_delay;
        end
        else
        begin
            rd_bits_reg  <= bits_mem[mem_raddr];
            rd_delay_reg <= delay_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_index_reg   <= '0;
            repeat_count_reg <= 8'd0;
            due_time_reg     <= 32'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_index_reg   <= step_index_next;
            repeat_count_reg <= repeat_count_next;
            due_time_reg     <= due_time_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pins_written_reg <= pins_written_next;
            pin_levels_reg   <= pin_levels_next;
            playing_reg      <= playing_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, playing_reg, pin_levels_reg, pins_written_reg};

endmodule

`default_nettype wire
